FILE: rtl/lpr_pkg.sv
`timescale 1ns / 1ps

package lpr_pkg;

	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;
	localparam int CFG_W         = 5;
	localparam int MISS_W        = 32;
	localparam int USER_W        = 2;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} lpr_cmd_t;

endpackage

FILE: rtl/lru_page_replacement.sv
`timescale 1ns / 1ps

// Fully associative LRU page-replacement engine. Each slave transfer carries one page
// reference; each master transfer carries its result: hit and eviction flags on m_tuser,
// the evicted page, the occupancy and the saturating miss count on m_tdata. A reference
// passes through capture, a parallel tag and recency lookup over all frames and a commit of
// the frame table; the commit waits while an undrained result holds the output register. The
// next reference is taken only after the last one commits, but while its result still waits in
// the output register. The capacity register may be written only while the block is idle; zero
// acts as one and values above FRAMES act as FRAMES. Lowering it never flushes pages.
module lru_page_replacement #(
	parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 s_tvalid,
	output logic                                                 s_tready,
	// page
	input  logic [((PAGE_BITS+7)/8)*8-1:0]                       s_tdata,
	output logic                                                 m_tvalid,
	input  logic                                                 m_tready,
	// evicted_page, occupancy, miss_total
	output logic [((PAGE_BITS+$clog2(FRAMES+1)+lpr_pkg::MISS_W+7)/8)*8-1:0] m_tdata,
	// hit, evicted_valid
	output logic [lpr_pkg::USER_W-1:0]                           m_tuser,
	input  logic                                                 cfg_we,
	input  logic [lpr_pkg::CFG_W-1:0]                            cfg_wdata
);

	localparam int OCC_W   = $clog2(FRAMES + 1);
	localparam int OUT_RAW = PAGE_BITS + OCC_W + lpr_pkg::MISS_W;
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

	lpr_pkg::lpr_cmd_t          cmd;
	logic                       out_hit;
	logic                       out_ev_valid;
	logic [PAGE_BITS-1:0]       out_ev_page;
	logic [OCC_W-1:0]           out_occ;
	logic [lpr_pkg::MISS_W-1:0] out_miss;

	lpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	lpr_datapath #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_page      (s_tdata[PAGE_BITS-1:0]),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_hit      (out_hit),
		.out_ev_valid (out_ev_valid),
		.out_ev_page  (out_ev_page),
		.out_occ      (out_occ),
		.out_miss     (out_miss)
	);

	assign m_tdata = OUT_W'({out_miss, out_occ, out_ev_page});
	assign m_tuser = {out_ev_valid, out_hit};

endmodule

FILE: rtl/lpr_ctrl.sv
`timescale 1ns / 1ps

module lpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output lpr_pkg::lpr_cmd_t cmd
);

	typedef enum logic [1:0] {
		IDLE,
		LOOKUP,
		COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit_ok;

	// result register is free or being drained this cycle
	assign commit_ok   = !out_valid_q || m_tready;
	assign cmd.capture = (state_q == IDLE) && s_tvalid;
	assign cmd.lookup  = (state_q == LOOKUP);
	assign cmd.commit  = (state_q == COMMIT) && commit_ok;
	assign s_tready    = (state_q == IDLE);
	assign m_tvalid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) state_q <= LOOKUP;
				end
				LOOKUP: begin
					state_q <= COMMIT;
				end
				COMMIT: begin
					if (commit_ok) state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/lpr_datapath.sv
`timescale 1ns / 1ps

module lpr_datapath #(
	parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lpr_pkg::lpr_cmd_t          cmd,
	input  logic [PAGE_BITS-1:0]       in_page,
	input  logic                       cfg_we,
	input  logic [lpr_pkg::CFG_W-1:0]  cfg_wdata,
	output logic                       out_hit,
	output logic                       out_ev_valid,
	output logic [PAGE_BITS-1:0]       out_ev_page,
	output logic [$clog2(FRAMES+1)-1:0] out_occ,
	output logic [lpr_pkg::MISS_W-1:0] out_miss
);

	localparam int OCC_W  = $clog2(FRAMES + 1);
	localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CMP_W  = (OCC_W > lpr_pkg::CFG_W) ? OCC_W : lpr_pkg::CFG_W;

	// frame table and recency state
	logic [PAGE_BITS-1:0]          frame_page_q [FRAMES];
	logic [FRAMES-1:0]             valid_q;
	logic [RANK_W-1:0]             rank_q [FRAMES];
	logic [OCC_W-1:0]              count_q;
	logic [lpr_pkg::MISS_W-1:0]    miss_q;
	logic [lpr_pkg::CFG_W-1:0]     cap_q;

	// captured reference and lookup results
	logic [PAGE_BITS-1:0]          page_q;
	logic [FRAMES-1:0]             match_q;
	logic [FRAMES-1:0]             victim_q;
	logic [FRAMES-1:0]             slot_q;
	logic                          hit_q;

	logic [FRAMES-1:0]             match_d;
	logic [FRAMES-1:0]             lru_d;
	logic [FRAMES-1:0]             victim_d;
	logic [FRAMES-1:0]             free_d;
	logic [FRAMES-1:0]             slot_d;
	logic [RANK_W-1:0]             last_rank;
	logic                          full_d;

	logic [PAGE_BITS-1:0]          ev_page;
	logic [RANK_W-1:0]             hit_rank;
	logic                          ev_valid;
	logic [OCC_W-1:0]              count_new;
	logic [lpr_pkg::MISS_W-1:0]    miss_new;

	assign last_rank = RANK_W'(count_q - OCC_W'(1));
	// capacity zero acts as one since count is nonzero here
	assign full_d = (count_q != '0) &&
		((count_q == OCC_W'(FRAMES)) || (CMP_W'(count_q) >= CMP_W'(cap_q)));

	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			match_d[i] = valid_q[i] && (frame_page_q[i] == page_q);
			lru_d[i]   = valid_q[i] && (rank_q[i] == last_rank);
		end
	end

	assign victim_d = (full_d && !(|match_d)) ? lru_d : '0;
	assign free_d   = ~(valid_q & ~victim_d);
	// lowest free frame
	assign slot_d = free_d & (~free_d + FRAMES'(1));

	always_comb begin
		ev_page  = '0;
		hit_rank = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (victim_q[i]) ev_page = ev_page | frame_page_q[i];
			if (match_q[i]) hit_rank = hit_rank | rank_q[i];
		end
	end

	assign ev_valid  = |victim_q;
	assign count_new = hit_q ? count_q : (ev_valid ? count_q : count_q + OCC_W'(1));
	assign miss_new  = (hit_q || (&miss_q)) ? miss_q : miss_q + lpr_pkg::MISS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			miss_q  <= '0;
			cap_q   <= lpr_pkg::CFG_W'(16);
			for (int i = 0; i < FRAMES; i++) rank_q[i] <= '0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.commit) begin
				for (int i = 0; i < FRAMES; i++) begin
					if (hit_q) begin
						if (match_q[i]) begin
							rank_q[i] <= '0;
						end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
							rank_q[i] <= rank_q[i] + RANK_W'(1);
						end
					end else begin
						// an evicted frame may be refilled at once
						if (slot_q[i]) begin
							valid_q[i] <= 1'b1;
							rank_q[i]  <= '0;
						end else if (victim_q[i]) begin
							valid_q[i] <= 1'b0;
						end else if (valid_q[i]) begin
							rank_q[i] <= rank_q[i] + RANK_W'(1);
						end
					end
				end
				count_q <= count_new;
				miss_q  <= miss_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) page_q <= in_page;
		if (cmd.lookup) begin
			match_q  <= match_d;
			victim_q <= victim_d;
			slot_q   <= slot_d;
			hit_q    <= |match_d;
		end
		if (cmd.commit) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (!hit_q && slot_q[i]) frame_page_q[i] <= page_q;
			end
			out_hit      <= hit_q;
			out_ev_valid <= ev_valid;
			out_ev_page  <= ev_page;
			out_occ      <= count_new;
			out_miss     <= miss_new;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == OCC_W'($countones(valid_q)))
		else $error("resident count differs from valid frames");

	a_lookup_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup |=> ($onehot0(match_q) && $onehot0(victim_q) && $onehot0(slot_q)))
		else $error("lookup vectors not one-hot");

	a_miss_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (miss_q >= $past(miss_q)))
		else $error("miss count went down");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup && (|match_d) |=> !(|victim_q))
		else $error("eviction on a hit");
`endif

endmodule

FILE: tb/lru_result_checker.sv
`timescale 1ns / 1ps

module lru_result_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	input  logic [((lpr_pkg::PAGE_BITS_DEF+7)/8)*8-1:0] s_tdata,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic [55:0]                           m_tdata,
	input  logic [lpr_pkg::USER_W-1:0]            m_tuser,
	input  logic                                  cfg_we,
	input  logic [lpr_pkg::CFG_W-1:0]             cfg_wdata,
	output int                                    fail_count,
	output int                                    outstanding
);

	localparam int FRAMES    = lpr_pkg::FRAMES_DEF;
	localparam int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF;
	localparam int OCC_W     = $clog2(FRAMES + 1);
	localparam int MISS_W    = lpr_pkg::MISS_W;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic                 hit;
		logic                 evicted_valid;
		logic [PAGE_BITS-1:0] evicted_page;
		logic [OCC_W-1:0]     occupancy;
		logic [MISS_W-1:0]    miss_total;
	} lru_result_t;

	logic [PAGE_BITS-1:0]     frame_page [FRAMES];
	logic                     frame_valid [FRAMES];
	int unsigned              frame_rank [FRAMES];
	int unsigned              resident;
	logic [MISS_W-1:0]        miss_count;
	logic [lpr_pkg::CFG_W-1:0] capacity;
	lru_result_t              predicted_results [$];

	task automatic look_up_page(input logic [PAGE_BITS-1:0] page, output lru_result_t res);
		int found;
		int victim;
		int slot;
		int unsigned cap;
		int unsigned r;
		found = -1;
		victim = -1;
		slot = -1;
		res = '0;
		cap = (capacity < 1) ? 1 : ((capacity > FRAMES) ? FRAMES : capacity);
		for (int i = 0; i < FRAMES; i++)
			if (found < 0 && frame_valid[i] && frame_page[i] == page)
				found = i;
		if (found >= 0) begin
			r = frame_rank[found];
			res.hit = 1'b1;
			for (int i = 0; i < FRAMES; i++)
				if (frame_valid[i] && frame_rank[i] < r)
					frame_rank[i]++;
			frame_rank[found] = 0;
		end else begin
			// full at the clamped capacity: drop the least recently used page first
			if (resident >= cap) begin
				for (int i = 0; i < FRAMES; i++)
					if (frame_valid[i] && (victim < 0 || frame_rank[i] > frame_rank[victim]))
						victim = i;
				if (victim >= 0) begin
					res.evicted_valid = 1'b1;
					res.evicted_page = frame_page[victim];
					frame_valid[victim] = 1'b0;
					frame_rank[victim] = 0;
					if (resident > 0)
						resident--;
				end
			end
			for (int i = 0; i < FRAMES; i++)
				if (slot < 0 && !frame_valid[i])
					slot = i;
			if (slot >= 0) begin
				for (int i = 0; i < FRAMES; i++)
					if (frame_valid[i])
						frame_rank[i]++;
				frame_valid[slot] = 1'b1;
				frame_page[slot] = page;
				frame_rank[slot] = 0;
				resident++;
			end
			if (miss_count != '1)
				miss_count++;
		end
		res.occupancy = resident[OCC_W-1:0];
		res.miss_total = miss_count;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lru_result_t got;
		lru_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) begin
				frame_page[i] = '0;
				frame_valid[i] = 1'b0;
				frame_rank[i] = 0;
			end
			resident = 0;
			miss_count = '0;
			capacity = lpr_pkg::CFG_W'(FRAMES);
			predicted_results.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.hit = m_tuser[0];
				got.evicted_valid = m_tuser[1];
				got.evicted_page = m_tdata[PAGE_BITS-1:0];
				got.occupancy = m_tdata[PAGE_BITS +: OCC_W];
				got.miss_total = m_tdata[PAGE_BITS+OCC_W +: MISS_W];
				if (predicted_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("%0t: result transfer with nothing pending", $time);
				end else begin
					want = predicted_results.pop_front();
					if (got != want) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display({"%0t: expected hit=%0d ev=%0d page=%h occ=%0d miss=%0d,",
								" got hit=%0d ev=%0d page=%h occ=%0d miss=%0d"}, $time,
								want.hit, want.evicted_valid, want.evicted_page,
								want.occupancy, want.miss_total, got.hit,
								got.evicted_valid, got.evicted_page, got.occupancy,
								got.miss_total);
					end
				end
			end
			if (cfg_we)
				capacity = cfg_wdata;
			if (s_tvalid && s_tready) begin
				look_up_page(s_tdata[PAGE_BITS-1:0], want);
				predicted_results = {predicted_results, want};
			end
		end
		outstanding = predicted_results.size();
	end

endmodule

FILE: tb/tb_lru_page_replacement.sv
`timescale 1ns / 1ps

module tb_lru_page_replacement;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 135;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic [15:0]                   s_tdata = '0;
	logic                          m_tready = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [lpr_pkg::CFG_W-1:0]     cfg_wdata = '0;
	wire                           s_tready;
	wire                           m_tvalid;
	wire [55:0]                    m_tdata;
	wire [lpr_pkg::USER_W-1:0]     m_tuser;
	int                            fail_count;
	int                            outstanding;
	int                            cycle_count = 0;
	bit                            steady = 1'b0;
	int                            stall_left = 0;

	lru_page_replacement DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	lru_result_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_lru_page_replacement: done, errors");
			$finish;
		end
	end

	// mostly short idle stretches, now and then a long one
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 92)
			return $urandom_range(3, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!steady && $urandom_range(0, 99) < 20) begin
			stall_left = idle_length() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// returns at the falling edge after the transfer, tvalid still high
	task automatic send_page(input logic [15:0] page);
		int gap;
		gap = (!steady && $urandom_range(0, 99) < 35) ? idle_length() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= page;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic set_capacity(input logic [lpr_pkg::CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [lpr_pkg::CFG_W-1:0] cap, input int count);
		logic [15:0] working_set [32];
		int ws_size;
		set_capacity(cap);
		steady = ($urandom_range(0, 3) == 0);
		ws_size = $urandom_range(1, 24);
		for (int i = 0; i < 32; i++)
			working_set[i] = 16'($urandom_range(0, 16'hFFFF));
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 75)
				send_page(working_set[$urandom_range(0, ws_size - 1)]);
			else
				send_page(16'($urandom_range(0, 16'hFFFF)));
		end
		steady = 1'b0;
	endtask

	initial begin
		logic [lpr_pkg::CFG_W-1:0] phase_caps [8];
		phase_caps = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd12, 5'd1, 5'd17, 5'd6};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes, hits on both, then two more pages
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'hAAAA);
		send_page(16'h5555);
		// zero acts as one; occupancy above capacity is kept, not flushed
		set_capacity(5'd0);
		send_page(16'h1234);
		send_page(16'h0000);
		send_page(16'h8000);
		// above the frame count acts as the full frame count
		set_capacity(5'd31);
		for (int i = 0; i < 17; i++)
			send_page(16'h0100 + 16'(i));

		for (int p = 0; p < 8; p++)
			run_phase(phase_caps[p], PHASE_ITEMS);
		run_phase(5'($urandom_range(0, 31)), PHASE_ITEMS);

		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_lru_page_replacement: done, clean");
		else
			$display("tb_lru_page_replacement: done, errors");
		$finish;
	end

endmodule
